### src/crc15_packet_error_code_macros.svh
// Assertion macros for the CRC-15 PEC block
`ifndef CRC15_PACKET_ERROR_CODE_MACROS_SVH
`define CRC15_PACKET_ERROR_CODE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/crc15pec_pkg.sv
`timescale 1ns / 1ps
package crc15pec_pkg;

  typedef logic [14:0] rem_t;
  typedef logic [15:0] pec_t;
  typedef logic [7:0]  byte_t;

  localparam rem_t PEC_POLY = 15'h4599;
  localparam rem_t PEC_SEED = 15'd16;

  // Fold one byte into the remainder, MSB first
  function automatic rem_t crc15_byte_step(input rem_t rem, input byte_t data);
    rem_t r;
    r = rem ^ {data, 7'd0};
    for (int k = 0; k < 8; k++) begin
      if (r[14]) begin
        r = {r[13:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[13:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### src/crc15pec_in_if.sv
`timescale 1ns / 1ps
interface crc15pec_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] expected_pec;

  modport source(output valid, output data_byte, output last_byte, output expected_pec,
                 input ready);
  modport sink(input valid, input data_byte, input last_byte, input expected_pec,
               output ready);
endinterface

### src/crc15pec_out_if.sv
`timescale 1ns / 1ps
interface crc15pec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pec_value;
  logic        pec_match;

  modport source(output valid, output pec_value, output pec_match, input ready);
  modport sink(input valid, input pec_value, input pec_match, output ready);
endinterface

### src/crc15pec_rem.sv
`timescale 1ns / 1ps
module crc15pec_rem (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  crc15pec_pkg::byte_t data_byte,
  input  logic                last_byte,
  output crc15pec_pkg::pec_t  pec_code
);
  import crc15pec_pkg::*;

  rem_t rem;
  rem_t rem_next;

  assign rem_next = crc15_byte_step(rem, data_byte);
  assign pec_code = {rem_next, 1'b0};

  // Reseed after the closing word of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= PEC_SEED;
    end else if (step) begin
      rem <= last_byte ? PEC_SEED : rem_next;
    end
  end
endmodule

### src/crc15_packet_error_code.sv
`timescale 1ns / 1ps
// Channel  Modport  Word                                  Handshake
// bytes    sink     data_byte, last_byte, expected_pec    valid/ready
// result   source   pec_value, pec_match                  valid/ready
//
// One byte per cycle sustained while no closing byte is blocked; a word sits in
// the input register while the unrolled eight-bit CRC step runs, and a closing
// word's code then lands in the result register.
// Synchronous reset empties both registers and seeds the remainder with 16.
// A stalled result holds the result register; the input register keeps taking
// non-closing bytes meanwhile, and waits only when a closing byte is blocked.
module crc15_packet_error_code (
  input logic           clk,
  input logic           rst,
  crc15pec_in_if.sink   bytes,
  crc15pec_out_if.source result
);
  import crc15pec_pkg::*;

  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_last;
  pec_t  s1_expected;
  logic  advance;
  pec_t  pec_code;
  logic  out_valid;
  pec_t  out_value;
  logic  out_match;

  // A closing byte needs a free result register
  assign advance     = s1_valid && (!s1_last || !out_valid || result.ready);
  assign bytes.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_byte     <= bytes.data_byte;
      s1_last     <= bytes.last_byte;
      s1_expected <= bytes.expected_pec;
    end
  end

  crc15pec_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .pec_code  (pec_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_value <= pec_code;
      out_match <= (pec_code == s1_expected);
    end
  end

  assign result.valid     = out_valid;
  assign result.pec_value = out_value;
  assign result.pec_match = out_match;
endmodule

### src/crc15pec_checker.sv
`timescale 1ns / 1ps
`include "crc15_packet_error_code_macros.svh"
module crc15pec_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_value
);
  `PEC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PEC_ASSERT_IMP(a_lsb_zero, out_valid, !out_value[0], "pec_value LSB set")
  `PEC_ASSERT_IMP(a_no_stall, !out_valid, in_ready, "input stalled with result register free")
  `PEC_ASSERT_IMP(a_reset_clear, $past(rst), !out_valid, "result valid straight after reset")
endmodule

bind crc15_packet_error_code crc15pec_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (bytes.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.pec_value)
);

### tb/crc15_packet_error_code_tb.sv
`timescale 1ns / 1ps
module crc15_packet_error_code_tb;
  import crc15pec_pkg::*;

  typedef struct packed {
    pec_t value;
    logic match;
  } pec_result_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned RANDOM_ITEMS = 1400;

  logic clk = 1'b0;
  logic rst;

  crc15pec_in_if  bytes_if();
  crc15pec_out_if result_if();

  crc15_packet_error_code dut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_if),
    .result(result_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rem_t            pec_rem;
  pec_result_t     pending_pecs[$];
  int unsigned     errors;
  int unsigned     bytes_sent;
  int unsigned     burst_left;
  bit              gaps_on;
  int unsigned     result_hold_cycles;
  int unsigned     idle_cycles;

  // Fold one byte into the remainder, feeding each data bit into the top tap
  function automatic rem_t fold_byte(rem_t r, byte_t d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = r[14] ^ d[i];
      r = {r[13:0], 1'b0};
      if (fb) begin
        r = r ^ PEC_POLY;
      end
    end
    return r;
  endfunction

  function automatic pec_t code_after(rem_t r, byte_t d);
    return {fold_byte(r, d), 1'b0};
  endfunction

  // Half the time the right code, otherwise near misses, odd codes and noise
  function automatic pec_t pick_expected(pec_t code);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return code;
      4:          return code ^ (16'h1 << $urandom_range(1, 15));
      5:          return code | 16'h1;
      default:    return pec_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(byte_t d, logic last, pec_t exp_pec);
    int unsigned gap;
    pec_t        code;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        bytes_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    bytes_if.valid        <= 1'b1;
    bytes_if.data_byte    <= d;
    bytes_if.last_byte    <= last;
    bytes_if.expected_pec <= exp_pec;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    bytes_sent++;
    pec_rem = fold_byte(pec_rem, d);
    if (last) begin
      code = {pec_rem, 1'b0};
      pending_pecs.push_back('{value: code, match: (code == exp_pec)});
      pec_rem = PEC_SEED;
    end
  endtask

  task automatic send_frame(int unsigned len);
    byte_t d;
    for (int unsigned i = 0; i < len; i++) begin
      d = byte_t'($urandom_range(0, 255));
      if (i == len - 1) begin
        send_word(d, 1'b1, pick_expected(code_after(pec_rem, d)));
      end else begin
        send_word(d, 1'b0, pec_t'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic wait_results_drained();
    bytes_if.valid <= 1'b0;
    while (pending_pecs.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_byte_frames();
    send_word(8'h00, 1'b1, code_after(pec_rem, 8'h00));
    send_word(8'hff, 1'b1, code_after(pec_rem, 8'hff));
    send_word(8'h80, 1'b1, 16'hffff);
    send_word(8'h01, 1'b1, 16'h0000);
    // an odd code can never match
    send_word(8'h7f, 1'b1, code_after(pec_rem, 8'h7f) | 16'h1);
    send_word(8'haa, 1'b1, code_after(pec_rem, 8'haa) ^ 16'h8000);
  endtask

  task automatic test_multi_byte_frames();
    // expected code on inner bytes must be ignored
    send_word(8'hff, 1'b0, 16'hffff);
    send_word(8'h00, 1'b0, 16'h0000);
    send_word(8'h5a, 1'b1, code_after(pec_rem, 8'h5a));
    repeat (4) send_word(8'h00, 1'b0, 16'h0001);
    send_word(8'hff, 1'b1, code_after(pec_rem, 8'hff));
    send_word(8'h80, 1'b0, 16'h8000);
    send_word(8'h01, 1'b1, 16'hfffe);
  endtask

  task automatic test_result_backpressure();
    gaps_on = 1'b0;
    result_hold_cycles = LONG_HOLD;
    repeat (30) send_frame($urandom_range(1, 4));
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_frame($urandom_range(2, 10));
    wait_results_drained();
    send_frame($urandom_range(1, 5));
  endtask

  task automatic test_random_frames();
    int unsigned r;
    int unsigned target;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_frame($urandom_range(1, 6));
      end else if (r < 9) begin
        send_frame($urandom_range(7, 20));
      end else begin
        send_frame($urandom_range(21, 64));
      end
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    bytes_if.valid        <= 1'b0;
    bytes_if.data_byte    <= '0;
    bytes_if.last_byte    <= 1'b0;
    bytes_if.expected_pec <= '0;
    pec_rem    = PEC_SEED;
    errors     = 0;
    bytes_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_byte_frames();
    test_multi_byte_frames();
    test_result_backpressure();
    test_drain_pause();
    test_random_frames();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result-side stall pattern; a requested hold takes priority
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    result_if.ready <= 1'b0;
    result_hold_cycles = 0;
    mode = 0;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (result_hold_cycles != 0) begin
        result_if.ready <= 1'b0;
        repeat (result_hold_cycles) @(posedge clk);
        result_hold_cycles = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      phase++;
      case (mode)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= ($urandom_range(0, 1) == 1);
        2:       result_if.ready <= ($urandom_range(0, 3) == 0);
        default: result_if.ready <= ((phase % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    pec_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_pecs.size() == 0) begin
        $display("%0t: unexpected result pec_value %h pec_match %b", $time,
                 result_if.pec_value, result_if.pec_match);
        errors++;
      end else begin
        want = pending_pecs.pop_front();
        if (result_if.pec_value !== want.value) begin
          $display("%0t: pec_value expected %h actual %h", $time, want.value,
                   result_if.pec_value);
          errors++;
        end
        if (result_if.pec_match !== want.match) begin
          $display("%0t: pec_match expected %b actual %b", $time, want.match,
                   result_if.pec_match);
          errors++;
        end
      end
    end
  end

  // Count cycles in which no word moves on either side; stop with an error at the stall limit
  always @(posedge clk) begin
    if ((bytes_if.valid && bytes_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule

### crc15_packet_error_code.f
+incdir+src
src/crc15pec_pkg.sv
src/crc15pec_in_if.sv
src/crc15pec_out_if.sv
src/crc15pec_rem.sv
src/crc15_packet_error_code.sv
src/crc15pec_checker.sv
tb/crc15_packet_error_code_tb.sv
